### rtl/v3alu_pkg.sv
package v3alu_pkg;

  // Operation codes.
  localparam logic [3:0] OP_LEN     = 4'd0;
  localparam logic [3:0] OP_NORM    = 4'd1;
  localparam logic [3:0] OP_DIST    = 4'd2;
  localparam logic [3:0] OP_CROSS   = 4'd3;
  localparam logic [3:0] OP_DOT     = 4'd4;
  localparam logic [3:0] OP_LERP    = 4'd5;
  localparam logic [3:0] OP_MIN     = 4'd6;
  localparam logic [3:0] OP_MAX     = 4'd7;
  localparam logic [3:0] OP_CLAMP   = 4'd8;
  localparam logic [3:0] OP_REFLECT = 4'd9;
  localparam logic [3:0] OP_PROJECT = 4'd10;
  localparam logic [3:0] OP_ADD     = 4'd11;
  localparam logic [3:0] OP_SUB     = 4'd12;
  localparam logic [3:0] OP_MUL     = 4'd13;
  localparam logic [3:0] OP_DIV     = 4'd14;
  localparam logic [3:0] OP_SCALE   = 4'd15;

  // Q16.16 constants.
  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_z;
    logic signed [31:0] scalar_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] r_scalar;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } sat_t;

  typedef struct packed {
    logic        start;
    logic [63:0] rad;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [48:0] quo;
  } div_rsp_t;

  // Sign extension of a Q16.16 word to 64 bits.
  function automatic logic signed [63:0] ext64(input logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // Saturation to a 32-bit word with a clip flag.
  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t s;
    if (v > ext64(Q_MAX)) begin
      s.ovf = 1'b1;
      s.val = Q_MAX;
    end else if (v < ext64(Q_MIN)) begin
      s.ovf = 1'b1;
      s.val = Q_MIN;
    end else begin
      s.ovf = 1'b0;
      s.val = v[31:0];
    end
    return s;
  endfunction

  // Fixed-point product scaling, rounded toward minus infinity.
  function automatic logic signed [63:0] fm(input logic signed [63:0] p);
    return p >>> 16;
  endfunction

endpackage

### rtl/v3alu_queue.sv
module v3alu_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  v3alu_pkg::in_item_t   item,
  input  logic                  push,
  output logic                  full,
  output v3alu_pkg::in_item_t   head,
  output logic                  head_valid,
  input  logic                  take
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  v3alu_pkg::in_item_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_take;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_take    = take && head_valid;

  // Item storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_take) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_take) begin
        count <= count + 1'b1;
      end else if (do_take && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/v3alu_sqrt.sv
module v3alu_sqrt (
  input  logic                  clk,
  input  logic                  rst,
  input  v3alu_pkg::sqrt_req_t  req,
  output v3alu_pkg::sqrt_rsp_t  rsp
);

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [63:0] rad;
  logic [33:0] rem;
  logic [31:0] root;
  logic [35:0] rem_sh;
  logic [35:0] trial;

  // One result bit per cycle from two radicand bits.
  assign rem_sh = {rem, rad[63:62]};
  assign trial  = {2'b00, root, 2'b01};

  assign rsp.done = done;
  assign rsp.root = root;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rad  <= req.rad;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        if (rem_sh >= trial) begin
          rem  <= 34'(rem_sh - trial);
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= rem_sh[33:0];
          root <= {root[30:0], 1'b0};
        end
        rad <= {rad[61:0], 2'b00};
        cnt <= cnt + 1'b1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/v3alu_div.sv
module v3alu_div (
  input  logic                 clk,
  input  logic                 rst,
  input  v3alu_pkg::div_req_t  req,
  output v3alu_pkg::div_rsp_t  rsp
);

  logic        busy;
  logic        done;
  logic        neg;
  logic [5:0]  cnt;
  logic [47:0] dvd;
  logic [31:0] dmag;
  logic [32:0] rem;
  logic [32:0] rem_sh;
  logic [31:0] num_abs;
  logic [32:0] den_abs;

  // Magnitudes of the operands; the dividend is scaled by one in Q16.16.
  assign num_abs = req.num[31] ? 32'(-req.num) : req.num;
  assign den_abs = req.den[32] ? 33'(-req.den) : req.den;
  assign rem_sh  = {rem[31:0], dvd[47]};

  // Quotient truncates toward zero.
  assign rsp.done = done;
  assign rsp.quo  = neg ? 49'(-$signed({1'b0, dvd})) : $signed({1'b0, dvd});

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= req.num[31] ^ req.den[32];
        dvd  <= {num_abs, 16'h0000};
        dmag <= den_abs[31:0];
        rem  <= '0;
      end else if (busy) begin
        if (rem_sh >= {1'b0, dmag}) begin
          rem <= rem_sh - {1'b0, dmag};
          dvd <= {dvd[46:0], 1'b1};
        end else begin
          rem <= rem_sh;
          dvd <= {dvd[46:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/v3alu_core.sv
module v3alu_core (
  input  logic                  clk,
  input  logic                  rst,
  input  v3alu_pkg::in_item_t   item,
  input  logic                  item_valid,
  output logic                  take,
  input  logic                  pop,
  output v3alu_pkg::out_item_t  result,
  output logic                  res_valid
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PRE  = 4'd1;
  localparam logic [3:0] ST_SQ   = 4'd2;
  localparam logic [3:0] ST_SUM  = 4'd3;
  localparam logic [3:0] ST_ROOT = 4'd4;
  localparam logic [3:0] ST_NDIV = 4'd5;
  localparam logic [3:0] ST_CDIV = 4'd6;
  localparam logic [3:0] ST_MA   = 4'd7;
  localparam logic [3:0] ST_MB   = 4'd8;
  localparam logic [3:0] ST_DOT  = 4'd9;
  localparam logic [3:0] ST_MK   = 4'd10;
  localparam logic [3:0] ST_K    = 4'd11;
  localparam logic [3:0] ST_MN   = 4'd12;
  localparam logic [3:0] ST_FIN  = 4'd13;
  localparam logic [3:0] ST_OUT  = 4'd14;

  logic [3:0]         state;
  logic [3:0]         op;
  logic signed [31:0] a [3];
  logic signed [31:0] b [3];
  logic signed [31:0] c [3];
  logic signed [31:0] u [3];
  logic signed [31:0] n [3];
  logic signed [31:0] r [3];
  logic signed [63:0] p [3];
  logic signed [63:0] q [3];
  logic signed [31:0] s;
  logic signed [31:0] k;
  logic signed [31:0] rs;
  logic [31:0]        len;
  logic               ovf;
  logic [1:0]         idx;
  logic               dv_wait;
  v3alu_pkg::out_item_t res;

  logic signed [31:0] mx [3];
  logic signed [31:0] my [3];
  logic signed [63:0] pm [3];
  v3alu_pkg::sat_t    nega [3];
  v3alu_pkg::sat_t    dif [3];
  v3alu_pkg::sat_t    fr [3];
  v3alu_pkg::sat_t    dsat;
  v3alu_pkg::sat_t    ksat;
  v3alu_pkg::sat_t    qsat;
  logic signed [31:0] t;
  logic signed [31:0] onem;
  logic [3:0]         first_state;

  v3alu_pkg::sqrt_req_t sq_req;
  v3alu_pkg::sqrt_rsp_t sq_rsp;
  v3alu_pkg::div_req_t  dv_req;
  v3alu_pkg::div_rsp_t  dv_rsp;

  v3alu_sqrt u_sqrt (.clk(clk), .rst(rst), .req(sq_req), .rsp(sq_rsp));
  v3alu_div  u_div  (.clk(clk), .rst(rst), .req(dv_req), .rsp(dv_rsp));

  assign take      = (state == ST_IDLE) && item_valid;
  assign result    = res;

  // Shared units: the square root takes the sum of squares, the divider one lane at a time.
  assign sq_req.start = (state == ST_SUM);
  assign sq_req.rad   = p[0] + p[1] + p[2];
  assign dv_req.start = !dv_wait && ((state == ST_NDIV) || ((state == ST_CDIV) && (b[idx] != '0)));
  assign dv_req.num   = (state == ST_NDIV) ? u[idx] : a[idx];
  assign dv_req.den   = (state == ST_NDIV) ? $signed({1'b0, len}) : $signed({b[idx][31], b[idx]});
  assign qsat = v3alu_pkg::sat32($signed({{15{dv_rsp.quo[48]}}, dv_rsp.quo}));

  // Lerp factor limited to the unit interval.
  assign t    = (s < 0) ? 32'sd0 : ((s > v3alu_pkg::Q_ONE) ? v3alu_pkg::Q_ONE : s);
  assign onem = v3alu_pkg::Q_ONE - t;

  assign dsat = v3alu_pkg::sat32(v3alu_pkg::fm(p[0]) + v3alu_pkg::fm(p[1]) +
                                 v3alu_pkg::fm(p[2]));
  assign ksat = v3alu_pkg::sat32(v3alu_pkg::fm(p[0]));

  // Entry step chosen from the operation class.
  always_comb begin
    case (item.op)
      v3alu_pkg::OP_LEN, v3alu_pkg::OP_NORM,
      v3alu_pkg::OP_REFLECT, v3alu_pkg::OP_PROJECT: first_state = ST_SQ;
      v3alu_pkg::OP_DIST: first_state = ST_PRE;
      v3alu_pkg::OP_CROSS, v3alu_pkg::OP_LERP, v3alu_pkg::OP_MUL,
      v3alu_pkg::OP_SCALE, v3alu_pkg::OP_DOT: first_state = ST_MA;
      v3alu_pkg::OP_DIV: first_state = ST_CDIV;
      default: first_state = ST_FIN;
    endcase
  end

  // Per-lane negation and difference.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nega[i] = v3alu_pkg::sat32(-v3alu_pkg::ext64(a[i]));
      dif[i]  = v3alu_pkg::sat32(v3alu_pkg::ext64(b[i]) - v3alu_pkg::ext64(a[i]));
    end
  end

  // Multiplier operand selection for the three lanes.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mx[i] = a[i];
      my[i] = b[i];
    end
    case (state)
      ST_SQ: begin
        for (int i = 0; i < 3; i++) begin
          mx[i] = u[i];
          my[i] = u[i];
        end
      end
      ST_MA: begin
        case (op)
          v3alu_pkg::OP_CROSS: begin
            mx[0] = a[1]; my[0] = b[2];
            mx[1] = a[2]; my[1] = b[0];
            mx[2] = a[0]; my[2] = b[1];
          end
          v3alu_pkg::OP_LERP: begin
            for (int i = 0; i < 3; i++) my[i] = onem;
          end
          v3alu_pkg::OP_SCALE: begin
            for (int i = 0; i < 3; i++) my[i] = s;
          end
          v3alu_pkg::OP_REFLECT: begin
            for (int i = 0; i < 3; i++) begin
              mx[i] = nega[i].val;
              my[i] = n[i];
            end
          end
          v3alu_pkg::OP_PROJECT: begin
            for (int i = 0; i < 3; i++) my[i] = n[i];
          end
          default: ;
        endcase
      end
      ST_MB: begin
        if (op == v3alu_pkg::OP_CROSS) begin
          mx[0] = a[2]; my[0] = b[1];
          mx[1] = a[0]; my[1] = b[2];
          mx[2] = a[1]; my[2] = b[0];
        end else begin
          for (int i = 0; i < 3; i++) begin
            mx[i] = b[i];
            my[i] = t;
          end
        end
      end
      ST_MK: begin
        mx[0] = s;
        my[0] = k;
      end
      ST_MN: begin
        for (int i = 0; i < 3; i++) begin
          mx[i] = n[i];
          my[i] = k;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < 3; i++) pm[i] = v3alu_pkg::ext64(mx[i]) * v3alu_pkg::ext64(my[i]);
  end

  // Final per-lane result.
  always_comb begin
    v3alu_pkg::sat_t x;
    v3alu_pkg::sat_t y;
    v3alu_pkg::sat_t z;
    logic signed [31:0] m;
    for (int i = 0; i < 3; i++) begin
      x = v3alu_pkg::sat32(v3alu_pkg::fm(p[i]));
      y = v3alu_pkg::sat32(v3alu_pkg::fm(q[i]));
      z = '0;
      m = (a[i] > b[i]) ? a[i] : b[i];
      fr[i].ovf = 1'b0;
      fr[i].val = '0;
      case (op)
        v3alu_pkg::OP_CROSS:
          fr[i] = v3alu_pkg::sat32(v3alu_pkg::fm(p[i]) - v3alu_pkg::fm(q[i]));
        v3alu_pkg::OP_LERP: begin
          z = v3alu_pkg::sat32(v3alu_pkg::ext64(x.val) + v3alu_pkg::ext64(y.val));
          fr[i].val = z.val;
          fr[i].ovf = x.ovf | y.ovf | z.ovf;
        end
        v3alu_pkg::OP_MUL, v3alu_pkg::OP_SCALE, v3alu_pkg::OP_PROJECT:
          fr[i] = x;
        v3alu_pkg::OP_REFLECT: begin
          z = v3alu_pkg::sat32(v3alu_pkg::ext64(a[i]) + v3alu_pkg::ext64(x.val));
          fr[i].val = z.val;
          fr[i].ovf = x.ovf | z.ovf;
        end
        v3alu_pkg::OP_NORM: fr[i].val = n[i];
        v3alu_pkg::OP_ADD:
          fr[i] = v3alu_pkg::sat32(v3alu_pkg::ext64(a[i]) + v3alu_pkg::ext64(b[i]));
        v3alu_pkg::OP_SUB:
          fr[i] = v3alu_pkg::sat32(v3alu_pkg::ext64(a[i]) - v3alu_pkg::ext64(b[i]));
        v3alu_pkg::OP_MIN: fr[i].val = (a[i] < b[i]) ? a[i] : b[i];
        v3alu_pkg::OP_MAX: fr[i].val = m;
        v3alu_pkg::OP_CLAMP: fr[i].val = (m < c[i]) ? m : c[i];
        default: ;
      endcase
    end
  end

  // Result register occupancy: filled from the last step, emptied by pop.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == ST_OUT) && (!res_valid || pop)) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  // Sequencer; only control state is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      dv_wait   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            op   <= item.op;
            a[0] <= item.a_x; a[1] <= item.a_y; a[2] <= item.a_z;
            b[0] <= item.b_x; b[1] <= item.b_y; b[2] <= item.b_z;
            c[0] <= item.c_x; c[1] <= item.c_y; c[2] <= item.c_z;
            s    <= item.scalar_in;
            if ((item.op == v3alu_pkg::OP_REFLECT) || (item.op == v3alu_pkg::OP_PROJECT)) begin
              u[0] <= item.b_x; u[1] <= item.b_y; u[2] <= item.b_z;
            end else begin
              u[0] <= item.a_x; u[1] <= item.a_y; u[2] <= item.a_z;
            end
            for (int i = 0; i < 3; i++) r[i] <= '0;
            rs    <= '0;
            ovf   <= 1'b0;
            idx   <= '0;
            state <= first_state;
          end
        end
        ST_PRE: begin
          for (int i = 0; i < 3; i++) u[i] <= dif[i].val;
          ovf   <= ovf | dif[0].ovf | dif[1].ovf | dif[2].ovf;
          state <= ST_SQ;
        end
        ST_SQ: begin
          for (int i = 0; i < 3; i++) p[i] <= pm[i];
          state <= ST_SUM;
        end
        ST_SUM: begin
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (sq_rsp.done) begin
            len <= sq_rsp.root;
            case (op)
              v3alu_pkg::OP_NORM: begin
                state <= (sq_rsp.root == '0) ? ST_OUT : ST_NDIV;
              end
              v3alu_pkg::OP_REFLECT: begin
                if (sq_rsp.root == '0) begin
                  for (int i = 0; i < 3; i++) n[i] <= '0;
                  state <= ST_MA;
                end else begin
                  state <= ST_NDIV;
                end
              end
              v3alu_pkg::OP_PROJECT: begin
                if (sq_rsp.root > 32'd65536) begin
                  state <= ST_NDIV;
                end else begin
                  for (int i = 0; i < 3; i++) n[i] <= u[i];
                  state <= ST_MA;
                end
              end
              default: begin
                // Length and distance end here.
                rs    <= sq_rsp.root[31] ? v3alu_pkg::Q_MAX : $signed(sq_rsp.root);
                ovf   <= ovf | sq_rsp.root[31];
                state <= ST_OUT;
              end
            endcase
          end
        end
        ST_NDIV: begin
          if (!dv_wait) begin
            dv_wait <= 1'b1;
          end else if (dv_rsp.done) begin
            n[idx]  <= dv_rsp.quo[31:0];
            dv_wait <= 1'b0;
            if (idx == 2'd2) begin
              idx   <= '0;
              state <= (op == v3alu_pkg::OP_NORM) ? ST_FIN : ST_MA;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        ST_CDIV: begin
          if (b[idx] == '0) begin
            // Division by zero saturates toward the dividend's sign.
            r[idx] <= (a[idx] > 0) ? v3alu_pkg::Q_MAX :
                      ((a[idx] < 0) ? v3alu_pkg::Q_MIN : 32'sd0);
            ovf <= 1'b1;
            if (idx == 2'd2) state <= ST_OUT;
            else idx <= idx + 1'b1;
          end else if (!dv_wait) begin
            dv_wait <= 1'b1;
          end else if (dv_rsp.done) begin
            r[idx]  <= qsat.val;
            ovf     <= ovf | qsat.ovf;
            dv_wait <= 1'b0;
            if (idx == 2'd2) state <= ST_OUT;
            else idx <= idx + 1'b1;
          end
        end
        ST_MA: begin
          for (int i = 0; i < 3; i++) p[i] <= pm[i];
          if (op == v3alu_pkg::OP_REFLECT) begin
            ovf <= ovf | nega[0].ovf | nega[1].ovf | nega[2].ovf;
          end
          case (op)
            v3alu_pkg::OP_CROSS, v3alu_pkg::OP_LERP: state <= ST_MB;
            v3alu_pkg::OP_MUL, v3alu_pkg::OP_SCALE:  state <= ST_FIN;
            default: state <= ST_DOT;
          endcase
        end
        ST_MB: begin
          for (int i = 0; i < 3; i++) q[i] <= pm[i];
          state <= ST_FIN;
        end
        ST_DOT: begin
          k   <= dsat.val;
          ovf <= ovf | dsat.ovf;
          case (op)
            v3alu_pkg::OP_REFLECT: state <= ST_MK;
            v3alu_pkg::OP_PROJECT: state <= ST_MN;
            default: begin
              rs    <= dsat.val;
              state <= ST_OUT;
            end
          endcase
        end
        ST_MK: begin
          p[0]  <= pm[0];
          state <= ST_K;
        end
        ST_K: begin
          k     <= ksat.val;
          ovf   <= ovf | ksat.ovf;
          state <= ST_MN;
        end
        ST_MN: begin
          for (int i = 0; i < 3; i++) p[i] <= pm[i];
          state <= ST_FIN;
        end
        ST_FIN: begin
          for (int i = 0; i < 3; i++) r[i] <= fr[i].val;
          ovf   <= ovf | fr[0].ovf | fr[1].ovf | fr[2].ovf;
          state <= ST_OUT;
        end
        ST_OUT: begin
          // Hand the item to the result register once it is free.
          if (!res_valid || pop) begin
            res.r_x      <= r[0];
            res.r_y      <= r[1];
            res.r_z      <= r[2];
            res.r_scalar <= rs;
            res.overflow <= ovf;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/vector3_alu.sv
// Q16.16 3-D vector unit. Items enter an input queue of QUEUE_DEPTH entries at one per
// cycle until it is full; a sequencer behind it works on one item at a time and leaves
// the result in an output register that waits for pop while the next item starts.
// Add, subtract, min, max and clamp go straight to the final step; multiply, scale, cross,
// lerp and dot use the three-lane multiplier; length and distance wait on the 32-step
// square-root unit; normalize and reflect of a nonzero vector and project above unit length
// add three 48-step divisions one after another on the single shared divider to the
// square root, and component divide runs those three divisions alone (a lane with a
// zero divisor skips the divider).
module vector3_alu #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  v3alu_pkg::in_item_t   item,
  input  logic                  push,
  output logic                  full,
  output v3alu_pkg::out_item_t  result,
  output logic                  empty,
  input  logic                  pop
);

  v3alu_pkg::in_item_t head;
  logic head_valid;
  logic take;
  logic res_valid;

  assign empty = !res_valid;

  // Front: input queue.
  v3alu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .item(item), .push(push), .full(full),
    .head(head), .head_valid(head_valid), .take(take)
  );

  // Back: sequencer with shared arithmetic units.
  v3alu_core u_core (
    .clk(clk), .rst(rst), .item(head), .item_valid(head_valid), .take(take),
    .pop(pop), .result(result), .res_valid(res_valid)
  );

endmodule
